/* design/rcsfr_pkg.sv */
// Shared types and constants for the serial RC frame receiver.
package rcsfr_pkg;

    localparam int FRAME_LEN    = 32;
    localparam int NUM_CHANNELS = 10;
    localparam int POS_W        = $clog2(FRAME_LEN);
    localparam int CH_W         = 4;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 16;

    localparam logic [POS_W-1:0] LAST_POS   = POS_W'(FRAME_LEN - 1);
    localparam logic [POS_W-1:0] CK_LO_POS  = POS_W'(FRAME_LEN - 2);
    localparam logic [CH_W-1:0]  LAST_CH    = CH_W'(NUM_CHANNELS - 1);
    localparam logic [15:0]      SUM_INIT   = 16'hFFFF;
    localparam logic [15:0]      GAP_RESET  = 16'd3000;
    localparam logic [7:0]       SYNC_RESET = 8'h20;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_TIMEOUT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_VALUE  = 1'd1;

    typedef struct packed {
        logic [7:0]  rx_byte;
        logic [31:0] time_us;
    } t_in_item;

    typedef struct packed {
        logic            status;
        logic [CH_W-1:0] channel_index;
        logic [15:0]     channel_value;
        logic            last;
    } t_out_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_UPDATE,
        S_ERR,
        S_RD_LO,
        S_RD_HI,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic capture;
        logic update;
        logic rd_lo;
        logic rd_hi;
        logic load_err;
        logic load_ch;
        logic ch_clear;
    } t_ctrl_cmd;

    typedef struct packed {
        logic frame_done;
        logic sum_ok;
        logic can_load;
        logic ch_last;
    } t_dp_status;

endpackage

/* design/rc_serial_frame_receiver_unit.sv */
// Top level of the serial RC frame receiver: controller, datapath and assertions.
//
//  channel | direction | handshake            | payload
//  in      | input     | i_in_valid/o_in_stall | t_in_item (rx_byte, time_us)
//  out     | output    | o_out_valid/i_out_stall | t_out_item (status, index, value, last)
//  cfg     | input     | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
//  A byte that does not complete a frame is captured, then used in an update.
//  A completed frame with a bad checksum then goes through S_ERR; a good one
//  reads each channel in S_RD_LO, S_RD_HI and S_EMIT, through the single read port
//  of the frame store, one byte per read. A stalled output holds S_ERR or S_EMIT.
//  Reset is synchronous; the frame store has no reset and needs no clearing pass.
module rc_serial_frame_receiver_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  rcsfr_pkg::t_in_item              i_in_item,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output rcsfr_pkg::t_out_item             o_out_item,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [rcsfr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [rcsfr_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import rcsfr_pkg::*;

    t_ctrl_cmd  cmd;
    t_dp_status status;

    assign o_cfg_ready = 1'b1;

    rcsfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_stall (o_in_stall)
    );

    rcsfr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_item   (i_in_item),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    // One item at a time: busy right after an accept
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted while previous item in work");

    a_error_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status |->
            o_out_item.last && o_out_item.channel_index == '0 &&
            o_out_item.channel_value == '0)
        else $error("malformed error result");

    a_last_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.status |->
            o_out_item.last == (o_out_item.channel_index == LAST_CH))
        else $error("last flag does not match final channel");

    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.load_ch || cmd.load_err) |-> status.can_load)
        else $error("result loaded over a stalled result");

endmodule

/* design/rcsfr_ctrl.sv */
// Controller state machine: sequences byte update, frame check and result output.
module rcsfr_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  rcsfr_pkg::t_dp_status  i_status,
    output rcsfr_pkg::t_ctrl_cmd   o_cmd,
    output logic                   o_in_stall
);
    import rcsfr_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_UPDATE;
            end
            S_UPDATE: begin
                if (i_status.frame_done) begin
                    n_state = i_status.sum_ok ? S_RD_LO : S_ERR;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_ERR: begin
                if (i_status.can_load) n_state = S_IDLE;
            end
            S_RD_LO: n_state = S_RD_HI;
            S_RD_HI: n_state = S_EMIT;
            S_EMIT: begin
                if (i_status.can_load) begin
                    n_state = i_status.ch_last ? S_IDLE : S_RD_LO;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall    = 1'b0;
                o_cmd.capture = i_in_valid;
            end
            S_UPDATE: begin
                o_cmd.update   = 1'b1;
                o_cmd.ch_clear = 1'b1;
            end
            S_ERR:   o_cmd.load_err = i_status.can_load;
            S_RD_LO: o_cmd.rd_lo    = 1'b1;
            S_RD_HI: o_cmd.rd_hi    = 1'b1;
            S_EMIT:  o_cmd.load_ch  = i_status.can_load;
            default: o_cmd = '0;
        endcase
    end

endmodule

/* design/rcsfr_dp.sv */
// Datapath: config registers, gap test, frame store, running checksum, output register.
module rcsfr_dp (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  rcsfr_pkg::t_ctrl_cmd                   i_cmd,
    output rcsfr_pkg::t_dp_status                  o_status,
    input  rcsfr_pkg::t_in_item                    i_in_item,
    input  logic                                   i_cfg_we,
    input  logic [rcsfr_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [rcsfr_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    output logic                                   o_out_valid,
    output rcsfr_pkg::t_out_item                   o_out_item,
    input  logic                                   i_out_stall
);
    import rcsfr_pkg::*;

    logic [15:0]      r_gap_timeout;
    logic [7:0]       r_sync;
    logic [7:0]       r_byte;
    logic [31:0]      r_time;
    logic [31:0]      r_last_time;
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;
    logic [15:0]      r_sum;
    logic [7:0]       r_ck_lo;
    logic [CH_W-1:0]  r_ch;
    logic [7:0]       r_frame [FRAME_LEN];
    logic [7:0]       r_rdata;
    logic [7:0]       r_lo;
    logic             r_out_valid;
    t_out_item        r_out_item;

    logic [31:0]      gap_diff;
    logic             gap;
    logic [POS_W-1:0] eff_pos;
    logic             keep;
    logic [POS_W-1:0] rd_addr;
    logic             can_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gap_timeout <= GAP_RESET;
            r_sync        <= SYNC_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_GAP_TIMEOUT: r_gap_timeout <= i_cfg_data;
                CFG_SYNC_VALUE:  r_sync        <= i_cfg_data[7:0];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_byte <= i_in_item.rx_byte;
            r_time <= i_in_item.time_us;
        end
    end

    // Wrapping gap; an exactly equal gap does not restart the frame
    assign gap_diff = r_time - r_last_time;
    assign gap      = gap_diff > {16'd0, r_gap_timeout};
    assign eff_pos  = gap ? '0 : r_pos;
    assign keep     = (eff_pos != '0) || (r_byte == r_sync);

    always_comb begin
        n_pos = eff_pos;
        if (keep && eff_pos != LAST_POS) n_pos = eff_pos + POS_W'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_last_time <= '0;
        end else if (i_cmd.update) begin
            r_pos       <= n_pos;
            r_last_time <= r_time;
        end
    end

    // Running checksum over bytes 0..29; byte 30 held for the compare
    always_ff @(posedge i_clk) begin
        if (i_cmd.update && keep) begin
            if (eff_pos == '0) begin
                r_sum <= SUM_INIT - {8'd0, r_byte};
            end else if (eff_pos < CK_LO_POS) begin
                r_sum <= r_sum - {8'd0, r_byte};
            end
            if (eff_pos == CK_LO_POS) r_ck_lo <= r_byte;
        end
    end

    assign rd_addr = {r_ch, 1'b0} + (i_cmd.rd_hi ? POS_W'(3) : POS_W'(2));

    always_ff @(posedge i_clk) begin
        if (i_cmd.update && keep) r_frame[eff_pos] <= r_byte;
        if (i_cmd.rd_lo || i_cmd.rd_hi) r_rdata <= r_frame[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_hi) r_lo <= r_rdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch <= '0;
        end else if (i_cmd.ch_clear) begin
            r_ch <= '0;
        end else if (i_cmd.load_ch) begin
            r_ch <= r_ch + CH_W'(1);
        end
    end

    assign can_load = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_err || i_cmd.load_ch) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_err) begin
            r_out_item <= '{status: 1'b1, channel_index: '0, channel_value: '0,
                            last: 1'b1};
        end else if (i_cmd.load_ch) begin
            r_out_item <= '{status: 1'b0, channel_index: r_ch,
                            channel_value: {r_rdata, r_lo}, last: (r_ch == LAST_CH)};
        end
    end

    assign o_status.frame_done = keep && (eff_pos == LAST_POS);
    assign o_status.sum_ok     = r_sum == {r_byte, r_ck_lo};
    assign o_status.can_load   = can_load;
    assign o_status.ch_last    = r_ch == LAST_CH;

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

/* test/rc_serial_frame_receiver_unit_test.sv */
// Self-checking testbench for the serial RC frame receiver: directed frames, then random traffic.
module rc_serial_frame_receiver_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rcsfr_pkg::*;

    localparam int SETTLE_CYCLES = 40;
    localparam int LONG_HOLD     = 300;
    localparam int QUIET_LIMIT   = 3000;

    typedef logic [7:0] t_frame [FRAME_LEN];

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in_item              i_in_item;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out_item             o_out_item;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    rc_serial_frame_receiver_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Decoder image kept by the testbench
    t_frame          frame_img;
    logic [POS_W-1:0] frame_pos;
    logic [31:0]     prev_time_us;
    logic [15:0]     gap_limit;
    logic [7:0]      sync_byte;
    t_out_item       decoded_q[$];

    logic [31:0] now_us;
    bit          in_idle_on;
    bit          out_idle_on;
    int          stall_left;
    int          hold_left;
    int          fail_count;
    int          results_seen;
    int          quiet_cycles;

    initial i_clk = 1'b0;
    always #6 i_clk = ~i_clk;

    // Fill in the two checksum bytes of a frame
    function automatic t_frame sealed_frame(input t_frame fr);
        logic [15:0] ck;
        ck = SUM_INIT;
        for (int i = 0; i < FRAME_LEN - 2; i++) ck = ck - 16'(fr[i]);
        fr[CK_LO_POS] = ck[7:0];
        fr[LAST_POS]  = ck[15:8];
        return fr;
    endfunction

    function automatic t_frame random_frame();
        t_frame fr;
        fr[0] = sync_byte;
        for (int i = 1; i < FRAME_LEN; i++) fr[i] = 8'($urandom_range(0, 255));
        return sealed_frame(fr);
    endfunction

    // Last byte that makes the held frame check clean
    function automatic logic [7:0] good_last_byte();
        t_frame f;
        f = sealed_frame(frame_img);
        return f[LAST_POS];
    endfunction

    function automatic void decode_byte(input t_in_item it);
        logic [31:0] delta;
        t_frame      want;
        t_out_item   r;
        delta = it.time_us - prev_time_us;
        if (delta > 32'(gap_limit)) frame_pos = '0;
        prev_time_us = it.time_us;
        if (frame_pos == '0 && it.rx_byte != sync_byte) return;
        frame_img[frame_pos] = it.rx_byte;
        if (frame_pos != LAST_POS) begin
            frame_pos = frame_pos + POS_W'(1);
            return;
        end
        // position holds at the last slot; every later byte re-checks the frame
        want = sealed_frame(frame_img);
        if ({want[LAST_POS], want[CK_LO_POS]} != {frame_img[LAST_POS], frame_img[CK_LO_POS]}) begin
            r.status        = 1'b1;
            r.channel_index = '0;
            r.channel_value = '0;
            r.last          = 1'b1;
            decoded_q.push_back(r);
        end else begin
            for (int k = 0; k < NUM_CHANNELS; k++) begin
                r.status        = 1'b0;
                r.channel_index = CH_W'(k);
                r.channel_value = {frame_img[3 + 2 * k], frame_img[2 + 2 * k]};
                r.last          = (k == NUM_CHANNELS - 1);
                decoded_q.push_back(r);
            end
        end
    endfunction

    task automatic send_byte(input logic [7:0] b, input logic [31:0] step);
        int idle;
        idle = in_idle_on ? $urandom_range(0, 5) : 0;
        @(negedge i_clk);
        if (idle > 0) begin
            i_in_valid = 1'b0;
            repeat (idle) @(negedge i_clk);
        end
        now_us = now_us + step;
        i_in_item.rx_byte = b;
        i_in_item.time_us = now_us;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        decode_byte(i_in_item);
    endtask

    // First byte always follows a gap, so the frame starts clean
    task automatic send_frame(input t_frame fr, input int count, input int step);
        logic [31:0] s;
        send_byte(fr[0], 32'(gap_limit) + 1 + $urandom_range(0, 500));
        for (int i = 1; i < count; i++) begin
            s = (step < 0) ? 32'($urandom_range(0, gap_limit)) : 32'(step);
            send_byte(fr[i], s);
        end
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (decoded_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        wait_drained();
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_GAP_TIMEOUT) gap_limit = val;
        else if (idx == CFG_SYNC_VALUE) sync_byte = val[7:0];
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic test_default_frame();
        t_frame fr;
        send_byte(8'h21, 32'd100);
        fr = random_frame();
        fr[2] = 8'h00;
        fr[3] = 8'h00;
        fr[20] = 8'hFF;
        fr[21] = 8'hFF;
        send_frame(sealed_frame(fr), FRAME_LEN, 87);
    endtask

    // Frame is held at the end: each further byte overwrites the last slot
    task automatic test_checksum_hold();
        logic [7:0] good_hi;
        good_hi = good_last_byte();
        send_byte(~good_hi, 32'd10);
        send_byte(good_hi, 32'd10);
        send_byte(~good_hi, 32'd10);
    endtask

    task automatic test_gap_edge();
        logic [7:0] good_hi;
        write_reg(CFG_GAP_TIMEOUT, 16'd100);
        good_hi = good_last_byte();
        // a gap equal to the limit keeps the held frame
        send_byte(good_hi, 32'd100);
        // one above the limit restarts; the byte is kept at position zero only if it matches the sync value
        send_byte(good_hi, 32'd101);
        send_byte(good_hi, 32'd1);
    endtask

    task automatic test_cfg_extremes();
        write_reg(CFG_GAP_TIMEOUT, 16'hFFFF);
        write_reg(CFG_SYNC_VALUE, 16'h00FF);
        send_frame(random_frame(), FRAME_LEN, 65535);
        // upper data bits of the sync write are dropped
        write_reg(CFG_GAP_TIMEOUT, 16'd0);
        write_reg(CFG_SYNC_VALUE, 16'hFF00);
        send_byte(good_last_byte(), 32'd0);
    endtask

    task automatic test_backpressure();
        wait_drained();
        in_idle_on = 1'b0;
        hold_left = LONG_HOLD;
        repeat (4) send_byte(good_last_byte(), 32'd0);
        wait_drained();
        in_idle_on = 1'b1;
    endtask

    // A timestamp behind the last one has a wrapped difference far above the limit
    task automatic test_time_wrap();
        logic [7:0] good_hi;
        good_hi = good_last_byte();
        send_byte(good_hi, 32'hFFFF_FFF0);
        send_byte(good_hi, 32'd0);
    endtask

    task automatic test_random_traffic();
        t_frame fr;
        int     sent;
        int     seen_base;
        int     pick;
        write_reg(CFG_GAP_TIMEOUT, 16'($urandom_range(1, 65535)));
        write_reg(CFG_SYNC_VALUE, 16'($urandom_range(0, 65535)));
        sent = 0;
        seen_base = results_seen;
        while (sent < 32 || results_seen - seen_base < 10) begin
            pick = $urandom_range(0, 9);
            in_idle_on  = ($urandom_range(0, 3) != 0);
            out_idle_on = ($urandom_range(0, 3) != 0);
            fr = random_frame();
            if (pick <= 5) begin
                send_frame(fr, FRAME_LEN, -1);
                sent += FRAME_LEN;
            end else if (pick == 6) begin
                fr[$urandom_range(1, FRAME_LEN - 1)] ^= 8'(1 << $urandom_range(0, 7));
                send_frame(fr, FRAME_LEN, -1);
                sent += FRAME_LEN;
            end else if (pick == 7) begin
                pick = $urandom_range(2, FRAME_LEN - 1);
                send_frame(fr, pick, -1);
                sent += pick;
            end else if (pick == 8) begin
                repeat ($urandom_range(1, 6)) begin
                    send_byte(8'($urandom_range(0, 255)), $urandom());
                    sent++;
                end
            end else begin
                send_frame(fr, FRAME_LEN, -1);
                repeat ($urandom_range(1, 2)) begin
                    send_byte($urandom_range(0, 1) ? fr[LAST_POS] : 8'($urandom_range(0, 255)),
                              32'($urandom_range(0, gap_limit)));
                    sent++;
                end
                sent += FRAME_LEN;
            end
        end
    endtask

    // Receiver side stall
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_out_stall = 1'b1;
                hold_left--;
            end else if (stall_left > 0) begin
                i_out_stall = 1'b1;
                stall_left--;
            end else begin
                i_out_stall = 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : check_out
        t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            results_seen++;
            stall_left = out_idle_on ? $urandom_range(0, 5) : 0;
            if (decoded_q.size() == 0) begin
                $error("unexpected result: status %0d index %0d value %h last %0d",
                       o_out_item.status, o_out_item.channel_index,
                       o_out_item.channel_value, o_out_item.last);
                fail_count++;
            end else begin
                want = decoded_q.pop_front();
                if (o_out_item.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_out_item.status);
                    fail_count++;
                end
                if (o_out_item.channel_index !== want.channel_index) begin
                    $error("channel_index: expected %0d, got %0d",
                           want.channel_index, o_out_item.channel_index);
                    fail_count++;
                end
                if (o_out_item.channel_value !== want.channel_value) begin
                    $error("channel_value: expected %h, got %h",
                           want.channel_value, o_out_item.channel_value);
                    fail_count++;
                end
                if (o_out_item.last !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_out_item.last);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_in_item    = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        frame_img    = '{default: 8'h00};
        frame_pos    = '0;
        prev_time_us = '0;
        gap_limit    = GAP_RESET;
        sync_byte    = SYNC_RESET;
        // start near the top so the first frame crosses the counter wrap
        now_us       = 32'hFFFF_F000;
        in_idle_on   = 1'b1;
        out_idle_on  = 1'b1;
        stall_left   = 0;
        hold_left    = 0;
        fail_count   = 0;
        results_seen = 0;
        quiet_cycles = 0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_default_frame();
        test_checksum_hold();
        test_gap_edge();
        test_cfg_extremes();
        test_backpressure();
        test_time_wrap();
        test_random_traffic();

        wait_drained();
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

/* files.f */
design/rcsfr_pkg.sv
design/rcsfr_ctrl.sv
design/rcsfr_dp.sv
design/rc_serial_frame_receiver_unit.sv
test/rc_serial_frame_receiver_unit_test.sv
